[hdl/pcd_pkg.sv]
`default_nettype none
package pcd_pkg;

    localparam logic [7:0] CH_PCT = 8'h25;
    localparam logic [7:0] CH_0   = 8'h30;
    localparam logic [7:0] CH_9   = 8'h39;
    localparam logic [7:0] CH_A   = 8'h41;
    localparam logic [7:0] CH_F   = 8'h46;
    localparam logic [3:0] HEX_TEN = 4'd10;

    localparam int GRP_MAX = 3;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_PCT  = 2'd1,
        PH_HEX  = 2'd2
    } t_phase;

    typedef struct packed {
        logic [GRP_MAX-1:0][7:0] bytes;
        logic [1:0]              cnt;
        logic                    last;
    } t_group;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || ((c >= CH_A) && (c <= CH_F));
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        d = is_digit(c) ? (c - CH_0) : (c - CH_A);
        return is_digit(c) ? d[3:0] : (HEX_TEN + d[3:0]);
    endfunction

endpackage
`default_nettype wire

[hdl/percent_escape_decoder.sv]
`default_nettype none
// A word's first result is valid in the cycle after the word is accepted.
// Throughput: one input word per cycle when each gives at most one result and
// i_ready does not stall the output; a word that gives two or three results
// holds the output group register, and no next group loads, until its last is taken.
// Reset (synchronous, active low) clears the escape phase and output valid.
module percent_escape_decoder (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_in_last,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_out_last
);
    import pcd_pkg::*;

    t_group grp;
    logic   load;
    logic   can_take;
    logic   accept;

    assign o_ready = can_take;
    assign accept  = i_valid && can_take;

    pcd_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_in_byte),
        .i_last   (i_in_last),
        .o_grp    (grp),
        .o_load   (load)
    );

    pcd_serial u_serial (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_grp      (grp),
        .o_can_take (can_take),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_byte     (o_out_byte),
        .o_last     (o_out_last)
    );

endmodule
`default_nettype wire

[hdl/pcd_decode.sv]
`default_nettype none
module pcd_decode (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic [7:0]    i_byte,
    input  wire logic          i_last,
    output pcd_pkg::t_group    o_grp,
    output logic               o_load
);
    import pcd_pkg::*;

    t_phase     r_phase, n_phase;
    logic [7:0] r_first, n_first;
    t_group     grp;

    always_comb begin
        n_phase = PH_IDLE;
        n_first = r_first;
        grp.bytes = '0;
        grp.cnt = 2'd0;
        grp.last = i_last;
        case (r_phase)
            PH_PCT: begin
                if (is_hex(i_byte) && !i_last) begin
                    n_first = i_byte;
                    n_phase = PH_HEX;
                end else begin
                    grp.bytes[0] = CH_PCT;
                    grp.bytes[1] = i_byte;
                    grp.cnt = 2'd2;
                end
            end
            PH_HEX: begin
                if (is_hex(i_byte)) begin
                    grp.bytes[0] = {hex_value(r_first), hex_value(i_byte)};
                    grp.cnt = 2'd1;
                end else begin
                    grp.bytes[0] = CH_PCT;
                    grp.bytes[1] = r_first;
                    grp.bytes[2] = i_byte;
                    grp.cnt = 2'd3;
                end
            end
            default: begin
                if ((i_byte == CH_PCT) && !i_last) begin
                    n_phase = PH_PCT;
                end else begin
                    grp.bytes[0] = i_byte;
                    grp.cnt = 2'd1;
                end
            end
        endcase
    end

    assign o_grp  = grp;
    assign o_load = i_accept && (grp.cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_first <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_first <= n_first;
        end
    end

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_last) |=> (r_phase == PH_IDLE))
        else $error("escape pending after final word");

    a_hold_has_hex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HEX) |-> is_hex(r_first))
        else $error("held digit is not hex");

endmodule
`default_nettype wire

[hdl/pcd_serial.sv]
`default_nettype none
module pcd_serial (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_load,
    input  pcd_pkg::t_group    i_grp,
    output logic               o_can_take,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [7:0]         o_byte,
    output logic               o_last
);
    import pcd_pkg::*;

    t_group     r_grp;
    logic       r_valid;
    logic [1:0] r_idx;
    logic       at_end;
    logic       take_end;

    assign at_end     = (r_idx == (r_grp.cnt - 2'd1));
    assign take_end   = r_valid && i_ready && at_end;
    assign o_can_take = !r_valid || take_end;

    assign o_valid = r_valid;
    assign o_byte  = r_grp.bytes[r_idx];
    assign o_last  = r_grp.last && at_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= 2'd0;
        end else if (take_end) begin
            r_valid <= 1'b0;
        end else if (r_valid && i_ready) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_grp <= i_grp;
        end
    end

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ((r_grp.cnt != 2'd0) && (r_idx < r_grp.cnt)))
        else $error("word index outside group");

    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_can_take)
        else $error("group loaded over pending words");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_ready && !at_end && !i_load) |=> (r_valid && (r_idx == $past(r_idx) + 2'd1)))
        else $error("group did not advance");

endmodule
`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import pcd_pkg::*;

    typedef struct {
        logic [7:0] b;
        logic       last;
        logic       drain;
    } t_in_word;

    typedef struct {
        logic [7:0] b;
        logic       last;
    } t_out_word;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [7:0] i_in_byte;
    logic       i_in_last;
    logic       o_valid;
    logic       i_ready;
    logic [7:0] o_out_byte;
    logic       o_out_last;

    percent_escape_decoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_in_byte  (i_in_byte),
        .i_in_last  (i_in_last),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_byte (o_out_byte),
        .o_out_last (o_out_last)
    );

    t_in_word  pending_q[$];
    t_out_word decoded_q[$];

    t_phase     esc_phase;
    logic [7:0] held_digit;

    int   errors;
    int   words_in;
    bit   word_taken;
    int   burst_left;
    int   gap_left;
    int   hold_left;
    bit   long_hold_done;
    int   mode_left;
    int   rx_mode;
    int   n_random;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    initial begin
        #2ms;
        $display("FAIL percent_escape_decoder");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("mismatch %s: got %02h want %02h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic bit upper_hex(input logic [7:0] c);
        return (c >= CH_0 && c <= CH_9) || (c >= CH_A && c <= CH_F);
    endfunction

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [7:0] d;
        if (c <= CH_9) begin
            d = c - CH_0;
            return d[3:0];
        end
        d = c - CH_A;
        return HEX_TEN + d[3:0];
    endfunction

    task automatic push_result(input logic [7:0] b, input logic last);
        t_out_word w;
        w.b = b;
        w.last = last;
        decoded_q.push_back(w);
    endtask

    task automatic decode_word(input logic [7:0] b, input logic last);
        case (esc_phase)
            PH_PCT: begin
                if (upper_hex(b) && !last) begin
                    held_digit = b;
                    esc_phase = PH_HEX;
                end else begin
                    push_result(CH_PCT, 1'b0);
                    push_result(b, last);
                    esc_phase = PH_IDLE;
                end
            end
            PH_HEX: begin
                if (upper_hex(b)) begin
                    push_result({nibble_of(held_digit), nibble_of(b)}, last);
                end else begin
                    push_result(CH_PCT, 1'b0);
                    push_result(held_digit, 1'b0);
                    push_result(b, last);
                end
                esc_phase = PH_IDLE;
            end
            default: begin
                if (b == CH_PCT && !last) begin
                    esc_phase = PH_PCT;
                end else begin
                    push_result(b, last);
                    esc_phase = PH_IDLE;
                end
            end
        endcase
    endtask

    task automatic add_word(input logic [7:0] b, input logic last, input logic drain = 1'b0);
        t_in_word w;
        w.b = b;
        w.last = last;
        w.drain = drain;
        pending_q.push_back(w);
    endtask

    function automatic logic [7:0] rand_hex();
        int v;
        v = $urandom_range(0, 15);
        return (v < 10) ? CH_0 + 8'(v) : CH_A + 8'(v - 10);
    endfunction

    function automatic logic [7:0] rand_breaker();
        case ($urandom_range(0, 7))
            0: return 8'h61 + 8'($urandom_range(0, 5));
            1: return 8'h47;
            2: return 8'h2f;
            3: return 8'h3a;
            4: return 8'h40;
            5: return CH_PCT;
            6: return 8'h00;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic add_random_string(input logic drain_first);
        logic [7:0] s[$];
        int segs;
        int k;
        segs = $urandom_range(1, 4);
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6)) s.push_back(8'($urandom_range(0, 255)));
        end else begin
            for (k = 0; k < segs; k++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: begin
                        s.push_back(CH_PCT);
                        s.push_back(rand_hex());
                        s.push_back(rand_hex());
                    end
                    4, 5: begin
                        s.push_back(CH_PCT);
                        if ($urandom_range(0, 1)) s.push_back(rand_hex());
                        s.push_back(rand_breaker());
                    end
                    6, 7, 8: s.push_back(8'($urandom_range(0, 255)));
                    default: s.push_back($urandom_range(0, 1) ? CH_PCT : rand_hex());
                endcase
            end
        end
        for (k = 0; k < s.size(); k++) begin
            add_word(s[k], k == s.size() - 1, drain_first && k == 0);
            n_random++;
        end
    endtask

    initial begin
        errors = 0;
        words_in = 0;
        word_taken = 1'b0;
        burst_left = 1;
        gap_left = 0;
        hold_left = 0;
        long_hold_done = 1'b0;
        mode_left = 0;
        rx_mode = 0;
        n_random = 0;
        esc_phase = PH_IDLE;
        held_digit = 8'h00;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_in_byte = 8'h00;
        i_in_last = 1'b0;
        i_ready = 1'b0;

        add_word(CH_PCT, 1'b0); add_word(8'h34, 1'b0); add_word(8'h31, 1'b1);
        add_word(CH_PCT, 1'b0); add_word(CH_0, 1'b0);  add_word(CH_0, 1'b0);
        add_word(CH_PCT, 1'b0); add_word(CH_F, 1'b0);  add_word(CH_F, 1'b0);
        add_word(CH_PCT, 1'b1);
        add_word(CH_PCT, 1'b0); add_word(8'h39, 1'b1);
        add_word(CH_PCT, 1'b0); add_word(8'h41, 1'b0); add_word(8'h47, 1'b1);
        add_word(CH_PCT, 1'b0); add_word(CH_PCT, 1'b0);
        add_word(CH_PCT, 1'b0); add_word(8'h61, 1'b0);
        add_word(CH_PCT, 1'b0); add_word(8'h39, 1'b0); add_word(8'h2f, 1'b0);
        add_word(8'h00, 1'b0);  add_word(8'hff, 1'b0); add_word(8'h3a, 1'b1);

        while (n_random < 225) begin
            add_random_string(n_random == 0 || (n_random >= 110 && n_random < 116));
        end

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (pending_q.size() != 0 || i_valid || decoded_q.size() != 0);
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS percent_escape_decoder");
        end else begin
            $display("FAIL percent_escape_decoder");
        end
        $finish;
    end

    always @(negedge i_clk) begin
        t_in_word cur;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || word_taken) begin
            word_taken = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (pending_q.size() == 0 ||
                         (pending_q[0].drain && decoded_q.size() != 0)) begin
                i_valid <= 1'b0;
            end else begin
                cur = pending_q.pop_front();
                i_valid <= 1'b1;
                i_in_byte <= cur.b;
                i_in_last <= cur.last;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 16);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        logic rdy;
        if (!i_rst_n) begin
            rdy = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else if (!long_hold_done && words_in >= 120) begin
            long_hold_done = 1'b1;
            hold_left = 80;
            rdy = 1'b0;
        end else begin
            if (mode_left == 0) begin
                mode_left = $urandom_range(8, 40);
                rx_mode = $urandom_range(0, 2);
            end
            mode_left--;
            case (rx_mode)
                0: rdy = 1'b1;
                1: rdy = 1'($urandom_range(0, 1));
                default: rdy = ($urandom_range(0, 3) == 0);
            endcase
        end
        i_ready <= rdy;
    end

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (decoded_q.size() == 0) begin
                    report_mismatch("unexpected word", o_out_byte, 8'h00);
                end else begin
                    want = decoded_q.pop_front();
                    if (o_out_byte !== want.b)
                        report_mismatch("out_byte", o_out_byte, want.b);
                    if (o_out_last !== want.last)
                        report_mismatch("out_last", {7'b0, o_out_last}, {7'b0, want.last});
                end
            end
            if (i_valid && o_ready) begin
                word_taken = 1'b1;
                words_in++;
                decode_word(i_in_byte, i_in_last);
            end
        end
    end

endmodule
